>>> rtl/lrr_pkg.sv
// Shared types, codes and defaults for the lossy report ring.
package lrr_pkg;

	localparam int RING_DEPTH_DEF       = 16;
	localparam int MAX_REPORT_BYTES_DEF = 64;
	localparam int PARKED_READS_DEF     = 4;
	localparam int CMDQ_DEPTH           = 2;

	localparam int LEN_W  = 7;
	localparam int BYTE_W = 8;
	localparam int ST_W   = 3;
	localparam int OP_W   = 2;

	localparam logic [OP_W-1:0] OP_POST  = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_PEEK  = 2'd2;
	localparam logic [OP_W-1:0] OP_DRAIN = 2'd3;

	localparam logic [ST_W-1:0] ST_OK          = 3'd0;
	localparam logic [ST_W-1:0] ST_PENDING     = 3'd1;
	localparam logic [ST_W-1:0] ST_TOO_SMALL   = 3'd2;
	localparam logic [ST_W-1:0] ST_NO_ENTRY    = 3'd3;
	localparam logic [ST_W-1:0] ST_INVALID_LEN = 3'd4;
	localparam logic [ST_W-1:0] ST_REMOVED     = 3'd5;
	localparam logic [ST_W-1:0] ST_QUEUE_FULL  = 3'd6;

	typedef enum logic [2:0] {
		KIND_STAGE,
		KIND_POST_END,
		KIND_READ,
		KIND_PEEK,
		KIND_DRAIN
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [BYTE_W-1:0]  data;
		logic [BYTE_W-1:0]  id;
		logic [BYTE_W-1:0]  cap;
	} cmd_t;

endpackage

>>> rtl/lrr_front.sv
// Input stage: accept words and classify them into commands.
module lrr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,  // data_byte, report_id, reader_capacity
	input  logic [1:0]           s_axis_tuser,  // operation
	input  logic                 s_axis_tlast,
	output logic                 push_valid,
	input  logic                 push_ready,
	output lrr_pkg::cmd_t        push_data
);

	logic          cmd_v_s1;
	lrr_pkg::cmd_t cmd_s1;
	lrr_pkg::cmd_t cmd_in;

	always_comb begin
		cmd_in.data = s_axis_tdata[7:0];
		cmd_in.id   = s_axis_tdata[15:8];
		cmd_in.cap  = s_axis_tdata[23:16];
		case (s_axis_tuser)
			lrr_pkg::OP_POST: begin
				cmd_in.kind = s_axis_tlast ? lrr_pkg::KIND_POST_END : lrr_pkg::KIND_STAGE;
			end
			lrr_pkg::OP_READ: begin
				cmd_in.kind = lrr_pkg::KIND_READ;
			end
			lrr_pkg::OP_PEEK: begin
				cmd_in.kind = lrr_pkg::KIND_PEEK;
			end
			default: begin
				cmd_in.kind = lrr_pkg::KIND_DRAIN;
			end
		endcase
	end

	assign s_axis_tready = !cmd_v_s1 || push_ready;
	assign push_valid    = cmd_v_s1;
	assign push_data     = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_v_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			cmd_v_s1 <= 1'b1;
		end else if (push_ready) begin
			cmd_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1 <= cmd_in;
		end
	end

endmodule

>>> rtl/lrr_cmdq.sv
// Short command queue between front and back.
module lrr_cmdq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  lrr_pkg::cmd_t push_data,
	output logic          pop_valid,
	input  logic          pop,
	output lrr_pkg::cmd_t pop_data
);

	localparam int IW = (lrr_pkg::CMDQ_DEPTH > 1) ? $clog2(lrr_pkg::CMDQ_DEPTH) : 1;
	localparam int CW = $clog2(lrr_pkg::CMDQ_DEPTH + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(lrr_pkg::CMDQ_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(lrr_pkg::CMDQ_DEPTH);

	lrr_pkg::cmd_t slots_q [lrr_pkg::CMDQ_DEPTH];
	logic [IW-1:0] wr_q;
	logic [IW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (cnt_q != FULL_CNT);
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = slots_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST_IDX) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_IDX) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_q] <= push_data;
		end
	end

endmodule

>>> rtl/lrr_back.sv
// Command engine: staging, ring, parked reads, peek walk and result words.
module lrr_back #(
	parameter int RING_DEPTH       = lrr_pkg::RING_DEPTH_DEF,
	parameter int MAX_REPORT_BYTES = lrr_pkg::MAX_REPORT_BYTES_DEF,
	parameter int PARKED_READS     = lrr_pkg::PARKED_READS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	output logic                       q_pop,
	input  lrr_pkg::cmd_t              q_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [lrr_pkg::ST_W-1:0]   out_status,
	output logic [lrr_pkg::BYTE_W-1:0] out_byte,
	output logic [lrr_pkg::LEN_W-1:0]  out_len,
	output logic                       out_last,
	output logic                       out_completes
);

	localparam int LW   = lrr_pkg::LEN_W;
	localparam int BW   = lrr_pkg::BYTE_W;
	localparam int RI_W = $clog2(RING_DEPTH);
	localparam int RC_W = $clog2(RING_DEPTH + 1);
	localparam int SA_W = $clog2(RING_DEPTH * MAX_REPORT_BYTES);
	localparam int SI_W = (MAX_REPORT_BYTES > 1) ? $clog2(MAX_REPORT_BYTES) : 1;
	localparam int PI_W = (PARKED_READS > 1) ? $clog2(PARKED_READS) : 1;
	localparam int PC_W = $clog2(PARKED_READS + 1);
	localparam int PS_W = PC_W + 1;

	localparam logic [RI_W-1:0] RING_LAST = RI_W'(RING_DEPTH - 1);
	localparam logic [RC_W-1:0] RING_FULL = RC_W'(RING_DEPTH);
	localparam logic [LW-1:0]   MAX_LEN   = LW'(MAX_REPORT_BYTES);
	localparam logic [PC_W-1:0] PK_FULL   = PC_W'(PARKED_READS);
	localparam logic [PI_W-1:0] PK_LAST   = PI_W'(PARKED_READS - 1);
	localparam logic [PS_W-1:0] PK_MOD    = PS_W'(PARKED_READS);
	localparam logic [SA_W-1:0] SLOT_SPAN = SA_W'(MAX_REPORT_BYTES);

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_RD_LEN,
		S_PK_ADDR,
		S_PK_CHK,
		S_LOAD,
		S_EMIT,
		S_COPY,
		S_COPY_END,
		S_SINGLE,
		S_DRAIN
	} state_t;

	logic [BW-1:0] store_mem [RING_DEPTH * MAX_REPORT_BYTES];
	logic [LW-1:0] len_mem   [RING_DEPTH];
	logic [BW-1:0] stg_mem   [MAX_REPORT_BYTES];
	logic [BW-1:0] pcap_q    [PARKED_READS];

	state_t          state_q;
	lrr_pkg::cmd_t   cmd_q;
	logic [RI_W-1:0] head_q;
	logic [RI_W-1:0] tail_q;
	logic [RC_W-1:0] ecnt_q;
	logic [LW-1:0]   stg_cnt_q;
	logic            stg_ovf_q;
	logic [PI_W-1:0] phead_q;
	logic [PC_W-1:0] pcnt_q;
	logic [RI_W-1:0] pidx_q;
	logic [RC_W-1:0] remain_q;
	logic [SA_W-1:0] base_q;
	logic [LW-1:0]   len_q;
	logic [LW-1:0]   idx_q;
	logic            src_stg_q;
	logic            comp_q;
	logic [lrr_pkg::ST_W-1:0] res_status_q;
	logic            res_comp_q;
	logic            copy_v_s1;
	logic [SA_W-1:0] copy_addr_s1;
	logic [BW-1:0]   st_rdata_q;
	logic [LW-1:0]   len_rdata_q;
	logic [BW-1:0]   stg_rdata_q;

	logic            out_valid_q;
	logic [lrr_pkg::ST_W-1:0] out_status_q;
	logic [BW-1:0]   out_byte_q;
	logic [LW-1:0]   out_len_q;
	logic            out_last_q;
	logic            out_comp_q;

	logic            can_emit;
	logic            emit_fire;
	logic            out_load;
	logic [LW-1:0]   idx_sel;
	logic [SA_W-1:0] st_raddr;
	logic [SI_W-1:0] stg_raddr;
	logic [RI_W-1:0] len_raddr;
	logic            stg_we;
	logic            len_we;
	logic [RI_W-1:0] head_nx;
	logic [RI_W-1:0] tail_nx;
	logic [RI_W-1:0] tail_prev;
	logic [RI_W-1:0] pidx_prev;
	logic [PI_W-1:0] phead_nx;
	logic [PS_W-1:0] psum;
	logic [PI_W-1:0] pslot;
	logic            stg_room;
	logic [LW-1:0]   cnt_after;
	logic            ovf_after;
	logic [BW-1:0]   pcap_head;
	logic [SA_W-1:0] pidx_base;

	assign can_emit  = !out_valid_q || out_ready;
	assign emit_fire = (state_q == S_EMIT) && can_emit;
	assign out_load  = can_emit &&
		((state_q == S_EMIT) || (state_q == S_SINGLE) || (state_q == S_DRAIN));
	assign idx_sel   = emit_fire ? idx_q + LW'(1) : idx_q;
	assign q_pop     = (state_q == S_IDLE) && q_valid;

	assign head_nx   = (head_q == RING_LAST) ? '0 : head_q + 1'b1;
	assign tail_nx   = (tail_q == RING_LAST) ? '0 : tail_q + 1'b1;
	assign tail_prev = (tail_q == '0) ? RING_LAST : tail_q - 1'b1;
	assign pidx_prev = (pidx_q == '0) ? RING_LAST : pidx_q - 1'b1;
	assign phead_nx  = (phead_q == PK_LAST) ? '0 : phead_q + 1'b1;
	assign psum      = PS_W'(phead_q) + PS_W'(pcnt_q);
	assign pslot     = (psum >= PK_MOD) ? PI_W'(psum - PK_MOD) : PI_W'(psum);
	assign pcap_head = pcap_q[phead_q];
	assign pidx_base = SA_W'(pidx_q) * SLOT_SPAN;

	assign stg_room  = (stg_cnt_q < MAX_LEN);
	assign cnt_after = stg_room ? stg_cnt_q + LW'(1) : stg_cnt_q;
	assign ovf_after = stg_ovf_q || !stg_room;

	assign stg_we = (state_q == S_EXEC) && stg_room &&
		((cmd_q.kind == lrr_pkg::KIND_STAGE) || (cmd_q.kind == lrr_pkg::KIND_POST_END));
	assign len_we = (state_q == S_COPY_END);

	always_comb begin
		case (state_q)
			S_PK_ADDR: st_raddr = pidx_base;
			S_EMIT:    st_raddr = base_q + SA_W'(idx_sel);
			default:   st_raddr = base_q;
		endcase
		case (state_q)
			S_COPY:  stg_raddr = idx_q[SI_W-1:0];
			S_EMIT:  stg_raddr = idx_sel[SI_W-1:0];
			default: stg_raddr = '0;
		endcase
		case (state_q)
			S_PK_ADDR: len_raddr = pidx_q;
			default:   len_raddr = head_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (copy_v_s1) begin
			store_mem[copy_addr_s1] <= stg_rdata_q;
		end
		st_rdata_q <= store_mem[st_raddr];
	end

	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[tail_q] <= len_q;
		end
		len_rdata_q <= len_mem[len_raddr];
	end

	always_ff @(posedge clk) begin
		if (stg_we) begin
			stg_mem[stg_cnt_q[SI_W-1:0]] <= cmd_q.data;
		end
		stg_rdata_q <= stg_mem[stg_raddr];
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_EXEC) && (cmd_q.kind == lrr_pkg::KIND_READ) &&
				(ecnt_q == '0) && (pcnt_q != PK_FULL)) begin
			pcap_q[pslot] <= cmd_q.cap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			ecnt_q       <= '0;
			stg_cnt_q    <= '0;
			stg_ovf_q    <= 1'b0;
			phead_q      <= '0;
			pcnt_q       <= '0;
			pidx_q       <= '0;
			remain_q     <= '0;
			base_q       <= '0;
			len_q        <= '0;
			idx_q        <= '0;
			src_stg_q    <= 1'b0;
			comp_q       <= 1'b0;
			res_status_q <= lrr_pkg::ST_OK;
			res_comp_q   <= 1'b0;
			copy_v_s1    <= 1'b0;
			copy_addr_s1 <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= lrr_pkg::ST_OK;
			out_byte_q   <= '0;
			out_len_q    <= '0;
			out_last_q   <= 1'b0;
			out_comp_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			copy_v_s1    <= (state_q == S_COPY);
			copy_addr_s1 <= base_q + SA_W'(idx_q);
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						cmd_q   <= q_data;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (cmd_q.kind)
						lrr_pkg::KIND_STAGE: begin
							stg_cnt_q <= cnt_after;
							stg_ovf_q <= ovf_after;
							state_q   <= S_IDLE;
						end
						lrr_pkg::KIND_POST_END: begin
							stg_cnt_q <= '0;
							stg_ovf_q <= 1'b0;
							idx_q     <= '0;
							len_q     <= cnt_after;
							if (ovf_after) begin
								res_status_q <= lrr_pkg::ST_INVALID_LEN;
								res_comp_q   <= 1'b0;
								state_q      <= S_SINGLE;
							end else if (pcnt_q != '0) begin
								phead_q <= phead_nx;
								pcnt_q  <= pcnt_q - 1'b1;
								if (pcap_head < {1'b0, cnt_after}) begin
									res_status_q <= lrr_pkg::ST_TOO_SMALL;
									res_comp_q   <= 1'b1;
									state_q      <= S_SINGLE;
								end else begin
									src_stg_q <= 1'b1;
									comp_q    <= 1'b1;
									state_q   <= S_LOAD;
								end
							end else begin
								base_q  <= SA_W'(tail_q) * SLOT_SPAN;
								state_q <= S_COPY;
							end
						end
						lrr_pkg::KIND_READ: begin
							res_comp_q <= 1'b0;
							if (ecnt_q != '0) begin
								state_q <= S_RD_LEN;
							end else if (pcnt_q != PK_FULL) begin
								pcnt_q       <= pcnt_q + 1'b1;
								res_status_q <= lrr_pkg::ST_PENDING;
								state_q      <= S_SINGLE;
							end else begin
								res_status_q <= lrr_pkg::ST_QUEUE_FULL;
								state_q      <= S_SINGLE;
							end
						end
						lrr_pkg::KIND_PEEK: begin
							res_comp_q <= 1'b0;
							if (ecnt_q == '0) begin
								res_status_q <= lrr_pkg::ST_NO_ENTRY;
								state_q      <= S_SINGLE;
							end else begin
								pidx_q   <= tail_prev;
								remain_q <= ecnt_q;
								state_q  <= S_PK_ADDR;
							end
						end
						default: begin
							state_q <= S_DRAIN;
						end
					endcase
				end
				S_RD_LEN: begin
					head_q <= head_nx;
					ecnt_q <= ecnt_q - 1'b1;
					base_q <= SA_W'(head_q) * SLOT_SPAN;
					len_q  <= len_rdata_q;
					idx_q  <= '0;
					if (cmd_q.cap < {1'b0, len_rdata_q}) begin
						res_status_q <= lrr_pkg::ST_TOO_SMALL;
						state_q      <= S_SINGLE;
					end else begin
						src_stg_q <= 1'b0;
						comp_q    <= 1'b0;
						state_q   <= S_LOAD;
					end
				end
				S_PK_ADDR: begin
					base_q  <= pidx_base;
					state_q <= S_PK_CHK;
				end
				S_PK_CHK: begin
					if ((len_rdata_q != '0) && (st_rdata_q == cmd_q.id)) begin
						len_q <= len_rdata_q;
						idx_q <= '0;
						if (cmd_q.cap < {1'b0, len_rdata_q}) begin
							res_status_q <= lrr_pkg::ST_TOO_SMALL;
							state_q      <= S_SINGLE;
						end else begin
							src_stg_q <= 1'b0;
							comp_q    <= 1'b0;
							state_q   <= S_LOAD;
						end
					end else if (remain_q == RC_W'(1)) begin
						res_status_q <= lrr_pkg::ST_NO_ENTRY;
						state_q      <= S_SINGLE;
					end else begin
						pidx_q   <= pidx_prev;
						remain_q <= remain_q - 1'b1;
						state_q  <= S_PK_ADDR;
					end
				end
				S_LOAD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (can_emit) begin
						out_status_q <= lrr_pkg::ST_OK;
						out_byte_q   <= src_stg_q ? stg_rdata_q : st_rdata_q;
						out_len_q    <= len_q;
						out_last_q   <= (idx_q == len_q - LW'(1));
						out_comp_q   <= comp_q;
						idx_q        <= idx_q + LW'(1);
						if (idx_q == len_q - LW'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_COPY: begin
					idx_q <= idx_q + LW'(1);
					if (idx_q == len_q - LW'(1)) begin
						state_q <= S_COPY_END;
					end
				end
				S_COPY_END: begin
					if (ecnt_q == RING_FULL) begin
						head_q <= head_nx;
					end else begin
						ecnt_q <= ecnt_q + 1'b1;
					end
					tail_q       <= tail_nx;
					res_status_q <= lrr_pkg::ST_OK;
					res_comp_q   <= 1'b0;
					state_q      <= S_SINGLE;
				end
				S_SINGLE: begin
					if (can_emit) begin
						out_status_q <= res_status_q;
						out_byte_q   <= '0;
						out_len_q    <= '0;
						out_last_q   <= 1'b1;
						out_comp_q   <= res_comp_q;
						state_q      <= S_IDLE;
					end
				end
				S_DRAIN: begin
					if (can_emit) begin
						out_byte_q   <= '0;
						out_len_q    <= '0;
						out_status_q <= (pcnt_q == '0) ? lrr_pkg::ST_OK : lrr_pkg::ST_REMOVED;
						out_comp_q   <= (pcnt_q != '0);
						out_last_q   <= (pcnt_q <= PC_W'(1));
						if (pcnt_q <= PC_W'(1)) begin
							phead_q   <= '0;
							pcnt_q    <= '0;
							head_q    <= '0;
							tail_q    <= '0;
							ecnt_q    <= '0;
							stg_cnt_q <= '0;
							stg_ovf_q <= 1'b0;
							state_q   <= S_IDLE;
						end else begin
							phead_q <= phead_nx;
							pcnt_q  <= pcnt_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign out_status    = out_status_q;
	assign out_byte      = out_byte_q;
	assign out_len       = out_len_q;
	assign out_last      = out_last_q;
	assign out_completes = out_comp_q;

`ifndef ASSERT_OFF
	a_parked_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q <= PK_FULL)
		else $error("parked read count above slot count");
	a_ring_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ecnt_q <= RING_FULL)
		else $error("ring entry count above depth");
	a_emit_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (len_q != '0) && (idx_q < len_q))
		else $error("byte run index out of range");
	a_stage_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stg_cnt_q <= MAX_LEN)
		else $error("staging count above maximum");
`endif

endmodule

>>> rtl/lossy_report_ring_with_parked_reads.sv
// Top level: report ring with parked reads, front, command queue and back.
// Path: an accepted word passes the front register and the command queue into
// the back; a read fetches the entry length, a peek walks the ring back from the
// newest entry, and a post answers a parked read or copies each staged byte
// into the ring. Byte runs stream one word per cycle while m_axis_tready is
// high; the back takes a new command only after the previous one is done.
// Reset: arst_n clears ring, staging and parked-read state at once.
module lossy_report_ring_with_parked_reads #(
	parameter int RING_DEPTH       = lrr_pkg::RING_DEPTH_DEF,
	parameter int MAX_REPORT_BYTES = lrr_pkg::MAX_REPORT_BYTES_DEF,
	parameter int PARKED_READS     = lrr_pkg::PARKED_READS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // data_byte, report_id, reader_capacity
	input  logic [1:0]  s_axis_tuser,  // operation
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // data_byte_res, report_length, zero pad
	output logic [3:0]  m_axis_tuser,  // status, completes_parked_read
	output logic        m_axis_tlast
);

	logic          push_valid;
	logic          push_ready;
	lrr_pkg::cmd_t push_data;
	logic          pop_valid;
	logic          pop;
	lrr_pkg::cmd_t pop_data;
	logic [lrr_pkg::ST_W-1:0]   status;
	logic [lrr_pkg::BYTE_W-1:0] data_byte_res;
	logic [lrr_pkg::LEN_W-1:0]  report_length;
	logic                       completes_parked_read;

	lrr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_data     (push_data)
	);

	lrr_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_data   (pop_data)
	);

	lrr_back #(
		.RING_DEPTH       (RING_DEPTH),
		.MAX_REPORT_BYTES (MAX_REPORT_BYTES),
		.PARKED_READS     (PARKED_READS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (pop_valid),
		.q_pop         (pop),
		.q_data        (pop_data),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_status    (status),
		.out_byte      (data_byte_res),
		.out_len       (report_length),
		.out_last      (m_axis_tlast),
		.out_completes (completes_parked_read)
	);

	assign m_axis_tdata = {1'b0, report_length, data_byte_res};
	assign m_axis_tuser = {completes_parked_read, status};

endmodule
